/* rtl/pck_pkg.sv */
`default_nettype none
// ============================================================================
// pck_pkg
// Shared types, constants and AES helpers for the payload keystream cipher.
// ============================================================================
package pck_pkg;

    localparam int KEY_W  = 64;
    localparam int ADDR_W = 32;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [IDX_W-1:0] REG_NWK_HI = 3'd0;
    localparam logic [IDX_W-1:0] REG_NWK_LO = 3'd1;
    localparam logic [IDX_W-1:0] REG_APP_HI = 3'd2;
    localparam logic [IDX_W-1:0] REG_APP_LO = 3'd3;
    localparam logic [IDX_W-1:0] REG_DEVADDR = 3'd4;

    localparam logic [7:0] BLK_TAG = 8'h01;

    // classified item handed from front to back
    typedef struct packed {
        logic [7:0]   plain;
        logic         last;
        logic         new_blk;   // a fresh keystream block is needed
        logic [127:0] key;
        logic [127:0] ctr_blk;
        logic [3:0]   pos;
    } t_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } t_bk_state;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit block sits in bits [127-8i -: 8]
    function automatic logic [7:0] get_b(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    // one key-schedule step: next round key from current and rcon
    function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // SubBytes + ShiftRows (+ MixColumns unless final)
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic fin);
        logic [7:0] tmp [16];
        logic [7:0] st  [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) tmp[i] = SBOX[get_b(s, i)];
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) st[4*c+i] = tmp[4*((c+i)%4)+i];
        if (!fin) begin
            for (int c = 0; c < 4; c++) begin
                a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                st[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                st[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                st[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                st[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = st[i];
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/pck_front.sv */
`default_nettype none
// ============================================================================
// pck_front
// Accepts bytes, tracks frame position and builds the counter block and key.
// ============================================================================
module pck_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [7:0]         i_plain_byte,
    input  wire logic [31:0]        i_frame_counter,
    input  wire logic [7:0]         i_port_number,
    input  wire logic               i_first_of_frame,
    input  wire logic               i_end_of_frame,
    input  wire logic [127:0]       i_nwk_key,
    input  wire logic [127:0]       i_app_key,
    input  wire logic [31:0]        i_dev_addr,
    output pck_pkg::t_item          o_item
);
    logic [3:0]  r_byte_idx, n_byte_idx;
    logic [7:0]  r_blk_num,  n_blk_num;
    logic [31:0] r_fcnt,     n_fcnt;
    logic        r_use_nwk,  n_use_nwk;
    logic [3:0]  w_idx;
    logic [7:0]  w_num;
    logic [31:0] w_fcnt;
    logic        w_nwk;

    always_comb begin
        w_idx  = i_first_of_frame ? 4'd0 : r_byte_idx;
        w_num  = i_first_of_frame ? 8'd1 : r_blk_num;
        w_fcnt = i_first_of_frame ? i_frame_counter : r_fcnt;
        w_nwk  = i_first_of_frame ? (i_port_number == 8'd0) : r_use_nwk;
        o_item.plain   = i_plain_byte;
        o_item.last    = i_end_of_frame;
        o_item.new_blk = (w_idx == 4'd0);
        o_item.pos     = w_idx;
        o_item.key     = w_nwk ? i_nwk_key : i_app_key;
        o_item.ctr_blk = {pck_pkg::BLK_TAG, 32'd0, 8'd0,
                          i_dev_addr[7:0], i_dev_addr[15:8], i_dev_addr[23:16],
                          i_dev_addr[31:24],
                          w_fcnt[7:0], w_fcnt[15:8], w_fcnt[23:16], w_fcnt[31:24],
                          8'd0, w_num};
        n_fcnt    = w_fcnt;
        n_use_nwk = w_nwk;
        n_blk_num = (w_idx == 4'd0) ? w_num + 8'd1 : w_num;
        n_byte_idx = w_idx + 4'd1;
        if (i_end_of_frame) begin
            n_byte_idx = 4'd0;
            n_blk_num  = 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx <= 4'd0;
            r_blk_num  <= 8'd1;
            r_fcnt     <= 32'd0;
            r_use_nwk  <= 1'b0;
        end else if (i_push) begin
            r_byte_idx <= n_byte_idx;
            r_blk_num  <= n_blk_num;
            r_fcnt     <= n_fcnt;
            r_use_nwk  <= n_use_nwk;
        end
    end
endmodule
`default_nettype wire

/* rtl/pck_queue.sv */
`default_nettype none
// ============================================================================
// pck_queue
// Small FIFO between front and back; also used for the result side.
// ============================================================================
module pck_queue #(
    parameter int DEPTH = pck_pkg::QUEUE_DEPTH,
    parameter int W     = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_rd,
    output logic [W-1:0]      o_data,
    output logic              o_full,
    output logic              o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr = i_wr && !o_full;
    assign w_rd = i_rd && !o_empty;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (w_rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue overflow");
    a_no_rd_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |=> r_cnt <= (AW+1)'(1)) else $error("count jumped from empty");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_rd) |=> o_full) else $error("full dropped without read");
endmodule
`default_nettype wire

/* rtl/pck_back.sv */
`default_nettype none
// ============================================================================
// pck_back
// Iterative AES-128 (one round per cycle) and keystream XOR.
// ============================================================================
module pck_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  pck_pkg::t_item          i_item,
    output logic                    o_take,
    input  wire logic               i_out_full,
    output logic                    o_out_wr,
    output logic [8:0]              o_out_data
);
    pck_pkg::t_bk_state r_state, n_state;
    logic [127:0] r_ks, r_st, r_rk;
    logic [7:0]   r_rc;
    logic [3:0]   r_rnd;
    logic [7:0]   r_plain;
    logic [3:0]   r_pos;
    logic         r_last;
    logic [127:0] w_nrk, w_ks_sel;
    logic         w_start, w_done;
    logic [7:0]   w_ksb;

    assign w_nrk  = pck_pkg::key_next(r_rk, r_rc);
    assign w_done = (r_state == pck_pkg::ST_RUN) && (r_rnd == 4'd10);
    assign w_ks_sel = w_done ? (pck_pkg::aes_round(r_st, 1'b1) ^ w_nrk) : r_ks;

    always_comb begin
        n_state = r_state;
        o_take = 1'b0;
        o_out_wr = 1'b0;
        w_start = 1'b0;
        unique case (r_state)
            pck_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_item.new_blk) begin
                        o_take = 1'b1; w_start = 1'b1;
                        n_state = pck_pkg::ST_RUN;
                    end else if (!i_out_full) begin
                        o_take = 1'b1; o_out_wr = 1'b1;
                    end
                end
            end
            pck_pkg::ST_RUN: if (w_done) n_state = pck_pkg::ST_OUT;
            pck_pkg::ST_OUT: if (!i_out_full) begin
                o_out_wr = 1'b1;
                n_state = pck_pkg::ST_IDLE;
            end
            default: n_state = pck_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        if (r_state == pck_pkg::ST_OUT) w_ksb = r_ks[127-8*r_pos -: 8];
        else w_ksb = r_ks[127-8*i_item.pos -: 8];
    end
    assign o_out_data = (r_state == pck_pkg::ST_OUT) ? {r_plain ^ w_ksb, r_last}
                                                    : {i_item.plain ^ w_ksb, i_item.last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pck_pkg::ST_IDLE;
            r_ks <= '0;
        end else begin
            r_state <= n_state;
            r_ks <= w_ks_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_st <= i_item.ctr_blk ^ i_item.key;
            r_rk <= i_item.key;
            r_rc <= 8'h01;
            r_rnd <= 4'd1;
            r_plain <= i_item.plain;
            r_pos <= i_item.pos;
            r_last <= i_item.last;
        end else if (r_state == pck_pkg::ST_RUN) begin
            r_st <= pck_pkg::aes_round(r_st, 1'b0) ^ w_nrk;
            r_rk <= w_nrk;
            r_rc <= pck_pkg::xt(r_rc);
            r_rnd <= r_rnd + 4'd1;
        end
    end

    a_out_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_wr |-> !i_out_full) else $error("write to full result queue");
    a_run_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> r_state == pck_pkg::ST_OUT) else $error("missed output state");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == pck_pkg::ST_RUN && r_rnd == 4'd1)) else $error("bad start");
endmodule
`default_nettype wire

/* rtl/payload_ctr_keystream_cipher_top.sv */
`default_nettype none
// ============================================================================
// payload_ctr_keystream_cipher_top
// Frame payload AES-128 counter-mode encryption, one byte per beat.
// ============================================================================
// Input: push/full queue of payload bytes with frame counter, port and frame
// marks. Output: empty/pop queue of cipher bytes with last flag.
// Config: write-only port (i_cfg_we, i_cfg_idx, i_cfg_data), registers 0..4.
// The front latches frame fields and builds the counter block; a 4-entry
// queue feeds the back end, which runs AES-128 one round per cycle.
// A byte that opens a 16-byte block waits for load, the 10 rounds and
// output, and no new byte is taken meanwhile; the other 15 bytes reuse
// the stored keystream and go straight to the result queue. Reset clears
// frame state, keys and queues; block index returns to 1. When pop is
// held low the result queue fills, the back end stalls, then the input
// queue fills and full rises; no beat is lost.
// ============================================================================
module payload_ctr_keystream_cipher_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    output logic                            o_full,
    input  wire logic [7:0]                 i_plain_byte,
    input  wire logic [31:0]                i_frame_counter,
    input  wire logic [7:0]                 i_port_number,
    input  wire logic                       i_first_of_frame,
    input  wire logic                       i_end_of_frame,
    output logic                            o_empty,
    input  wire logic                       i_pop,
    output logic [7:0]                      o_cipher_byte,
    output logic                            o_last_out,
    input  wire logic                       i_cfg_we,
    input  wire logic [pck_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pck_pkg::CFG_W-1:0]  i_cfg_data
);
    localparam int IW = $bits(pck_pkg::t_item);
    logic [63:0] r_nwk_hi, r_nwk_lo, r_app_hi, r_app_lo;
    logic [31:0] r_dev;
    pck_pkg::t_item w_item, w_q_item;
    logic w_q_empty, w_take, w_out_full, w_out_wr;
    logic [8:0] w_out_data, w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nwk_hi <= '0; r_nwk_lo <= '0; r_app_hi <= '0; r_app_lo <= '0;
            r_dev <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pck_pkg::REG_NWK_HI:  r_nwk_hi <= i_cfg_data;
                pck_pkg::REG_NWK_LO:  r_nwk_lo <= i_cfg_data;
                pck_pkg::REG_APP_HI:  r_app_hi <= i_cfg_data;
                pck_pkg::REG_APP_LO:  r_app_lo <= i_cfg_data;
                pck_pkg::REG_DEVADDR: r_dev <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    pck_front u_front (
        .i_clk, .i_rst_n,
        .i_push(i_push && !o_full),
        .i_plain_byte, .i_frame_counter, .i_port_number,
        .i_first_of_frame, .i_end_of_frame,
        .i_nwk_key({r_nwk_hi, r_nwk_lo}),
        .i_app_key({r_app_hi, r_app_lo}),
        .i_dev_addr(r_dev),
        .o_item(w_item)
    );

    pck_queue #(.DEPTH(pck_pkg::QUEUE_DEPTH), .W(IW)) u_cmdq (
        .i_clk, .i_rst_n,
        .i_wr(i_push), .i_data(w_item),
        .i_rd(w_take), .o_data(w_q_item),
        .o_full(o_full), .o_empty(w_q_empty)
    );

    pck_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(!w_q_empty), .i_item(w_q_item),
        .o_take(w_take),
        .i_out_full(w_out_full), .o_out_wr(w_out_wr), .o_out_data(w_out_data)
    );

    pck_queue #(.DEPTH(2), .W(9)) u_resq (
        .i_clk, .i_rst_n,
        .i_wr(w_out_wr), .i_data(w_out_data),
        .i_rd(i_pop), .o_data(w_res),
        .o_full(w_out_full), .o_empty(o_empty)
    );

    assign o_cipher_byte = w_res[8:1];
    assign o_last_out    = w_res[0];
endmodule
`default_nettype wire
